/* sv/swrl_pkg.sv */
`timescale 1ns / 1ps

package swrl_pkg;

    localparam int CLASS_W  = 4;
    localparam int TIME_BITS = 31;
    localparam int LIMIT_W  = 8;
    localparam int UNIT_W   = 2;
    localparam int HITS_W   = 8;
    localparam int WIN_W    = 17;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int LOG_DEPTH_DEF   = 128;

    localparam int HITS_MAX = (1 << HITS_W) - 1;

    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 60 * 60;
    localparam int SEC_PER_DAY  = 60 * 60 * 24;

    typedef enum logic [UNIT_W-1:0] {
        UNIT_SECOND = 2'd0,
        UNIT_MINUTE = 2'd1,
        UNIT_HOUR   = 2'd2,
        UNIT_DAY    = 2'd3
    } swrl_unit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } swrl_state_t;

    typedef struct packed {
        logic [CLASS_W-1:0]   event_class;
        logic [TIME_BITS-1:0] now_seconds;
        logic [LIMIT_W-1:0]   limit_count;
        logic [UNIT_W-1:0]    window_unit;
        logic                 count_hit;
    } swrl_req_t;

    typedef struct packed {
        logic              limited;
        logic [HITS_W-1:0] window_hits;
    } swrl_rsp_t;

    function automatic logic [WIN_W-1:0] window_len(input logic [UNIT_W-1:0] unit);
        logic [WIN_W-1:0] len;
        unique case (swrl_unit_t'(unit))
            UNIT_SECOND: len = WIN_W'(1);
            UNIT_MINUTE: len = WIN_W'(SEC_PER_MIN);
            UNIT_HOUR:   len = WIN_W'(SEC_PER_HOUR);
            UNIT_DAY:    len = WIN_W'(SEC_PER_DAY);
            default:     len = WIN_W'(1);
        endcase
        return len;
    endfunction

endpackage

/* sv/swrl_log_store.sv */
`timescale 1ns / 1ps

module swrl_log_store #(
    parameter int NUM_CLASSES = 16,
    parameter int LOG_DEPTH   = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] cls,
    output logic [$clog2(LOG_DEPTH + 1)-1:0] fill_count,
    input  logic                            rd_en,
    input  logic [((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1)-1:0] rd_idx,
    output logic [swrl_pkg::TIME_BITS-1:0]  rd_time,
    input  logic                            app_en,
    input  logic [swrl_pkg::TIME_BITS-1:0]  app_time
);
    import swrl_pkg::*;

    localparam int IDX_W   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
    localparam int ENTRIES = NUM_CLASSES * LOG_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [TIME_BITS-1:0] hit_times_mem [ENTRIES];
    logic [TIME_BITS-1:0] rd_time_reg;

    logic [IDX_W-1:0] slot_reg [NUM_CLASSES];
    logic [IDX_W-1:0] slot_next;
    logic             full_reg [NUM_CLASSES];
    logic             full_next;
    logic             wrap;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Entries of a class are valid below the ring pointer, or all of them once it wrapped.
    assign fill_count = full_reg[cls] ? CNT_W'(LOG_DEPTH) : CNT_W'(slot_reg[cls]);

    assign rd_addr = ADDR_W'(int'(cls) * LOG_DEPTH + int'(rd_idx));
    assign wr_addr = ADDR_W'(int'(cls) * LOG_DEPTH + int'(slot_reg[cls]));

    assign wrap      = (int'(slot_reg[cls]) == LOG_DEPTH - 1);
    assign slot_next = wrap ? '0 : IDX_W'(slot_reg[cls] + 1'b1);
    assign full_next = full_reg[cls] | wrap;

    always_ff @(posedge clk)
    begin
        if (app_en)
        begin
            hit_times_mem[wr_addr] <= app_time;
        end
        if (rd_en)
        begin
            rd_time_reg <= hit_times_mem[rd_addr];
        end
    end

    assign rd_time = rd_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                slot_reg[k] <= '0;
                full_reg[k] <= 1'b0;
            end
        end
        else if (app_en)
        begin
            slot_reg[cls] <= slot_next;
            full_reg[cls] <= full_next;
        end
    end

endmodule

/* sv/sliding_window_rate_limiter_unit.sv */
`timescale 1ns / 1ps
// Each request scans the n logged hits of its class (0 to LOG_DEPTH); the log
// memory read port scans one entry a cycle. A new request is accepted only in
// the idle state, once the previous result has been issued; a result waiting in
// the output register does not block acceptance of the next request.
// Reset: asynchronous; clears ring pointers, fill flags and handshakes.
// The log memory itself is not cleared; entries beyond the fill level are never read.

module sliding_window_rate_limiter_unit #(
    parameter int NUM_CLASSES = swrl_pkg::NUM_CLASSES_DEF,
    parameter int LOG_DEPTH   = swrl_pkg::LOG_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  swrl_pkg::swrl_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output swrl_pkg::swrl_rsp_t rsp
);
    import swrl_pkg::*;

    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);

    swrl_state_t state_reg, state_next;

    logic [CLS_W-1:0]     cls_reg, cls_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic                 incr_reg, incr_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic                 pend_reg, pend_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    swrl_rsp_t            rsp_reg, rsp_next;

    logic [CLASS_W-1:0]   cls_mod;
    logic [CNT_W-1:0]     fill_count;
    logic                 rd_en;
    logic [TIME_BITS-1:0] rd_time;
    logic                 app_en;
    logic                 in_window;
    logic                 lim;
    logic                 out_free;

    swrl_log_store #(
        .NUM_CLASSES(NUM_CLASSES),
        .LOG_DEPTH  (LOG_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls_reg),
        .fill_count(fill_count),
        .rd_en     (rd_en),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_time   (rd_time),
        .app_en    (app_en),
        .app_time  (now_reg)
    );

    // Reduce the class number by restoring subtraction.
    always_comb
    begin
        logic [CLASS_W-1:0] r;
        r = req.event_class;
        for (int k = CLASS_W - 1; k >= 0; k--)
        begin
            if (int'(r) >= (NUM_CLASSES << k))
            begin
                r = CLASS_W'(int'(r) - (NUM_CLASSES << k));
            end
        end
        cls_mod = r;
    end

    assign in_window = ({1'b0, rd_time} + (TIME_BITS + 1)'(win_reg)) > {1'b0, now_reg};
    assign lim       = (hits_reg >= limit_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        now_next       = now_reg;
        limit_next     = limit_reg;
        win_next       = win_reg;
        incr_next      = incr_reg;
        idx_next       = idx_reg;
        hits_next      = hits_reg;
        pend_next      = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_en          = 1'b0;
        app_en         = 1'b0;
        req_stall      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cls_next   = CLS_W'(cls_mod);
                    now_next   = req.now_seconds;
                    limit_next = (int'(req.limit_count) > LOG_DEPTH) ?
                                 CNT_W'(LOG_DEPTH) : CNT_W'(req.limit_count);
                    win_next   = window_len(req.window_unit);
                    incr_next  = req.count_hit;
                    idx_next   = '0;
                    hits_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Count the entry read last cycle.
                if (pend_reg && in_window)
                begin
                    hits_next = CNT_W'(hits_reg + 1'b1);
                end
                if (idx_reg < fill_count)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = CNT_W'(idx_reg + 1'b1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    app_en                 = incr_reg && !lim;
                    rsp_valid_next         = 1'b1;
                    rsp_next.limited       = lim;
                    rsp_next.window_hits   = (int'(hits_reg) > HITS_MAX) ?
                                             HITS_W'(HITS_MAX) : HITS_W'(hits_reg);
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg   <= cls_next;
        now_reg   <= now_next;
        limit_reg <= limit_next;
        win_reg   <= win_next;
        incr_reg  <= incr_next;
        idx_reg   <= idx_next;
        hits_reg  <= hits_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
